/* rtl/drq_pkg.sv */
// ============================================================================
// drq_pkg: shared definitions of the disk request queue
// Field widths, result and command codes, and the structures that pass
// between the front end, the back end and the queues.
// ============================================================================
package drq_pkg;

   localparam int DRQ_QUEUE_DEPTH = 16;
   localparam int DRQ_CMD_DEPTH   = 4;
   localparam int DRQ_RSP_DEPTH   = 4;

   localparam int MINOR_W  = 8;
   localparam int SECTOR_W = 48;
   localparam int COUNT_W  = 17;
   localparam int BUFFER_W = 32;
   localparam int TAG_W    = 8;
   localparam int KIND_W   = 2;
   localparam int SLOT_W   = 4;
   localparam int TOTAL_W  = 48;

   // Input action codes.
   localparam logic ACT_ENQUEUE  = 1'b0;
   localparam logic ACT_COMPLETE = 1'b1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ISSUE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPURIOUS = 2'd3;

   // Commands from the front end to the back end.
   localparam logic [1:0] CMD_ISSUE    = 2'd0;
   localparam logic [1:0] CMD_COMPLETE = 2'd1;
   localparam logic [1:0] CMD_REJECT   = 2'd2;
   localparam logic [1:0] CMD_SPURIOUS = 2'd3;

   typedef struct packed {
      logic [MINOR_W-1:0]  minor;
      logic [SECTOR_W-1:0] sector;
      logic [COUNT_W-1:0]  count;
      logic                direction;
      logic [BUFFER_W-1:0] buffer;
      logic [TAG_W-1:0]    tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic      action;
      entry_type entry;
      logic      error;
   } req_type;

   typedef struct packed {
      logic [1:0] op;
      logic       has_next;
      logic       error;
      entry_type  entry;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SLOT_W-1:0]   slot;
      logic [MINOR_W-1:0]  minor;
      logic [SECTOR_W-1:0] sector;
      logic [COUNT_W-1:0]  count;
      logic                direction;
      logic [BUFFER_W-1:0] buffer;
      logic [TAG_W-1:0]    tag;
      logic                error;
      logic                from_completion;
      logic [TOTAL_W-1:0]  total;
      logic                last;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

endpackage

/* rtl/drq_ram.sv */
// ============================================================================
// drq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module drq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/drq_fifo.sv */
// ============================================================================
// drq_fifo: small register queue
// Holds up to DEPTH words; the oldest word is shown while empty is low.
// ============================================================================
module drq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/drq_front.sv */
// ============================================================================
// drq_front: request intake and classification
// Tracks the ring pointers and the busy flag, stores enqueued requests and
// hands at most one command per accepted item to the back end.
// ============================================================================
module drq_front
   import drq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DRQ_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  req_type                        req,
   input  logic                           ring_read,
   output logic                           next_pending,
   output logic                           cmd_push,
   output cmd_type                        cmd,
   output logic                           ram_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] ram_wr_addr,
   output logic [ENTRY_W-1:0]             ram_wr_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);

   // Each pointer is a slot plus a phase bit that flips on every wrap.
   logic [IDX_W-1:0] head_slot_ff, head_slot_in;
   logic             head_phase_ff, head_phase_in;
   logic [IDX_W-1:0] tail_slot_ff, tail_slot_in;
   logic             tail_phase_ff, tail_phase_in;
   logic             busy_ff, busy_in;
   logic             next_pending_ff, next_pending_in;
   logic [IDX_W-1:0] head_step_slot, tail_step_slot;
   logic             head_step_phase, tail_step_phase;
   logic             ring_full;

   assign ring_full = (head_slot_ff == tail_slot_ff) && (head_phase_ff != tail_phase_ff);

   // Set while the back end still has to read the next request out of the
   // ring; the input is held off until then so that slot stays intact.
   assign next_pending = next_pending_ff;

   always_comb begin
      head_step_slot  = (head_slot_ff == LAST_SLOT) ? '0 : head_slot_ff + IDX_W'(1);
      head_step_phase = (head_slot_ff == LAST_SLOT) ? !head_phase_ff : head_phase_ff;
      tail_step_slot  = (tail_slot_ff == LAST_SLOT) ? '0 : tail_slot_ff + IDX_W'(1);
      tail_step_phase = (tail_slot_ff == LAST_SLOT) ? !tail_phase_ff : tail_phase_ff;
   end

   always_comb begin
      head_slot_in    = head_slot_ff;
      head_phase_in   = head_phase_ff;
      tail_slot_in    = tail_slot_ff;
      tail_phase_in   = tail_phase_ff;
      busy_in         = busy_ff;
      next_pending_in = next_pending_ff;
      cmd_push        = 1'b0;
      cmd             = '0;
      cmd.entry       = req.entry;
      cmd.error       = req.error;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = tail_slot_ff;
      ram_wr_data     = req.entry;
      if (ring_read) begin
         next_pending_in = 1'b0;
      end
      if (accept) begin
         if (req.action == ACT_ENQUEUE) begin
            if (ring_full) begin
               cmd_push = 1'b1;
               cmd.op   = CMD_REJECT;
            end else begin
               ram_wr_en     = 1'b1;
               tail_slot_in  = tail_step_slot;
               tail_phase_in = tail_step_phase;
               if (!busy_ff) begin
                  busy_in  = 1'b1;
                  cmd_push = 1'b1;
                  cmd.op   = CMD_ISSUE;
               end
            end
         end else if (!busy_ff) begin
            cmd_push = 1'b1;
            cmd.op   = CMD_SPURIOUS;
         end else begin
            head_slot_in  = head_step_slot;
            head_phase_in = head_step_phase;
            cmd_push      = 1'b1;
            cmd.op        = CMD_COMPLETE;
            cmd.has_next  = (head_step_slot != tail_slot_ff) ||
                            (head_step_phase != tail_phase_ff);
            if (cmd.has_next) begin
               next_pending_in = 1'b1;
            end else begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_slot_ff    <= '0;
         head_phase_ff   <= 1'b0;
         tail_slot_ff    <= '0;
         tail_phase_ff   <= 1'b0;
         busy_ff         <= 1'b0;
         next_pending_ff <= 1'b0;
      end else begin
         head_slot_ff    <= head_slot_in;
         head_phase_ff   <= head_phase_in;
         tail_slot_ff    <= tail_slot_in;
         tail_phase_ff   <= tail_phase_in;
         busy_ff         <= busy_in;
         next_pending_ff <= next_pending_in;
      end
   end

endmodule

/* rtl/drq_back.sv */
// ============================================================================
// drq_back: command execution and result generation
// Keeps the in-flight request, the head slot and the sector total, reads the
// next request from the ring after a completion and writes result beats.
// ============================================================================
module drq_back
   import drq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DRQ_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   input  logic                           cmd_empty,
   output logic                           cmd_pop,
   input  logic                           rsp_full,
   output logic                           rsp_push,
   output rsp_type                        rsp,
   output logic                           ram_rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] ram_rd_addr,
   input  logic [ENTRY_W-1:0]             ram_rd_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_NEXT = 1'b1;

   logic               state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] flight_count_ff, flight_count_in;
   logic [TAG_W-1:0]   flight_tag_ff, flight_tag_in;
   logic [IDX_W-1:0]   head_step;
   logic [IDX_W+SLOT_W-1:0] head_ext;
   logic [TOTAL_W-1:0] total_sum;
   entry_type          ram_entry;

   assign head_step = (head_ff == LAST_SLOT) ? '0 : head_ff + IDX_W'(1);
   assign head_ext  = {{SLOT_W{1'b0}}, head_ff};
   assign total_sum = total_ff + TOTAL_W'(flight_count_ff);
   assign ram_entry = entry_type'(ram_rd_data);
   assign ram_rd_addr = head_step;

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      total_in        = total_ff;
      flight_count_in = flight_count_ff;
      flight_tag_in   = flight_tag_ff;
      cmd_pop         = 1'b0;
      rsp_push        = 1'b0;
      ram_rd_en       = 1'b0;
      rsp             = '0;
      rsp.total       = total_ff;
      rsp.last        = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop  = 1'b1;
               rsp_push = 1'b1;
               unique case (cmd.op)
                  CMD_ISSUE: begin
                     rsp.kind        = KIND_ISSUE;
                     rsp.slot        = head_ext[SLOT_W-1:0];
                     rsp.minor       = cmd.entry.minor;
                     rsp.sector      = cmd.entry.sector;
                     rsp.count       = cmd.entry.count;
                     rsp.direction   = cmd.entry.direction;
                     rsp.buffer      = cmd.entry.buffer;
                     rsp.tag         = cmd.entry.tag;
                     flight_count_in = cmd.entry.count;
                     flight_tag_in   = cmd.entry.tag;
                  end
                  CMD_COMPLETE: begin
                     rsp.kind  = KIND_DONE;
                     rsp.slot  = head_ext[SLOT_W-1:0];
                     rsp.count = flight_count_ff;
                     rsp.tag   = flight_tag_ff;
                     rsp.error = cmd.error;
                     rsp.total = total_sum;
                     rsp.last  = !cmd.has_next;
                     total_in  = total_sum;
                     head_in   = head_step;
                     if (cmd.has_next) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_NEXT;
                     end
                  end
                  CMD_REJECT: begin
                     rsp.kind = KIND_REJECT;
                     rsp.tag  = cmd.entry.tag;
                  end
                  CMD_SPURIOUS: begin
                     rsp.kind = KIND_SPURIOUS;
                  end
               endcase
            end
         end
         ST_NEXT: begin
            // The ring read started with the completion beat; its data is here now.
            if (!rsp_full) begin
               rsp_push            = 1'b1;
               rsp.kind            = KIND_ISSUE;
               rsp.slot            = head_ext[SLOT_W-1:0];
               rsp.minor           = ram_entry.minor;
               rsp.sector          = ram_entry.sector;
               rsp.count           = ram_entry.count;
               rsp.direction       = ram_entry.direction;
               rsp.buffer          = ram_entry.buffer;
               rsp.tag             = ram_entry.tag;
               rsp.from_completion = 1'b1;
               flight_count_in     = ram_entry.count;
               flight_tag_in       = ram_entry.tag;
               state_in            = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      flight_count_ff <= flight_count_in;
      flight_tag_ff   <= flight_tag_in;
   end

endmodule

/* rtl/disk_request_queue.sv */
// ============================================================================
// disk_request_queue: ring of disk transfer requests with a busy flag
// Accepts enqueue and completion items and reports issues, completions,
// rejections and spurious completions as result beats.
// ============================================================================
// The input side takes one beat per cycle whenever req_full is low; the front
// end classifies the item in that cycle against its own copy of the ring
// pointers and the busy flag, writes an enqueued request into the ring memory,
// and places at most one command in a four-entry command queue. The back end
// executes one command per cycle while idle and the result queue has room, and
// the first result beat of an item passes through the command and result
// queues before it can be popped. A completion followed by an issue from the
// ring takes the back end through its ST_NEXT state, because the next request
// comes through the registered read port of the ring memory; its issue beat
// follows the completion beat. From the acceptance of such a completion until
// the back end has read that next request, req_full stays high, even while the
// back end waits on the result queue, so a later enqueue never overwrites a
// slot that is still to be read. Results wait in a four-entry result queue, so
// the back end keeps working while the consumer stalls. No clearing pass is
// needed after reset; the ring slots are never read before they are written.
module disk_request_queue
   import drq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DRQ_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_action,
   input  logic [MINOR_W-1:0]    req_device_minor,
   input  logic [SECTOR_W-1:0]   req_start_sector,
   input  logic [COUNT_W-1:0]    req_sector_count,
   input  logic                  req_direction,
   input  logic [BUFFER_W-1:0]   req_buffer_addr,
   input  logic [TAG_W-1:0]      req_requester_tag,
   input  logic                  req_error_flag,
   // Result channel.
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic [MINOR_W-1:0]    rsp_out_minor,
   output logic [SECTOR_W-1:0]   rsp_out_sector,
   output logic [COUNT_W-1:0]    rsp_out_count,
   output logic                  rsp_out_direction,
   output logic [BUFFER_W-1:0]   rsp_out_buffer,
   output logic [TAG_W-1:0]      rsp_out_tag,
   output logic                  rsp_out_error,
   output logic                  rsp_from_completion,
   output logic [TOTAL_W-1:0]    rsp_total_sectors,
   output logic                  rsp_last
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   req_type            req;
   logic               req_accept;
   logic               next_pending;
   cmd_type            cmd_in_data, cmd_out_data;
   logic [CMD_W-1:0]   cmd_out_bits;
   logic               cmd_push, cmd_pop, cmd_full, cmd_empty;
   rsp_type            rsp_in_data, rsp_out_data;
   logic [RSP_W-1:0]   rsp_out_bits;
   logic               rsp_push, rsp_full;
   logic               ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   // Every accepted item can need one command, so the input stalls when the
   // command queue has no room, and also while a ring read is still owed.
   assign req_full   = cmd_full || next_pending;
   assign req_accept = req_push && !req_full;

   assign req.action          = req_action;
   assign req.entry.minor     = req_device_minor;
   assign req.entry.sector    = req_start_sector;
   assign req.entry.count     = req_sector_count;
   assign req.entry.direction = req_direction;
   assign req.entry.buffer    = req_buffer_addr;
   assign req.entry.tag       = req_requester_tag;
   assign req.error           = req_error_flag;

   drq_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req         (req),
      .ring_read   (ram_rd_en),
      .next_pending(next_pending),
      .cmd_push    (cmd_push),
      .cmd         (cmd_in_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   // The ring itself: one entry per slot, written by the front end and read by
   // the back end when a completion hands the device the next request.
   drq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Command queue between the front and back ends.
   drq_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(DRQ_CMD_DEPTH)
   ) u_cmd_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_data(cmd_in_data),
      .full   (cmd_full),
      .pop    (cmd_pop),
      .rd_data(cmd_out_bits),
      .empty  (cmd_empty)
   );

   assign cmd_out_data = cmd_type'(cmd_out_bits);

   drq_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd_out_data),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp        (rsp_in_data),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data)
   );

   // Result queue; its oldest beat drives the result ports directly.
   drq_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(DRQ_RSP_DEPTH)
   ) u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wr_data(rsp_in_data),
      .full   (rsp_full),
      .pop    (rsp_pop),
      .rd_data(rsp_out_bits),
      .empty  (rsp_empty)
   );

   assign rsp_out_data        = rsp_type'(rsp_out_bits);
   assign rsp_kind            = rsp_out_data.kind;
   assign rsp_slot            = rsp_out_data.slot;
   assign rsp_out_minor       = rsp_out_data.minor;
   assign rsp_out_sector      = rsp_out_data.sector;
   assign rsp_out_count       = rsp_out_data.count;
   assign rsp_out_direction   = rsp_out_data.direction;
   assign rsp_out_buffer      = rsp_out_data.buffer;
   assign rsp_out_tag         = rsp_out_data.tag;
   assign rsp_out_error       = rsp_out_data.error;
   assign rsp_from_completion = rsp_out_data.from_completion;
   assign rsp_total_sectors   = rsp_out_data.total;
   assign rsp_last            = rsp_out_data.last;

endmodule
